// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold in the same cycle as its trigger
`define AST_WHEN(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must hold in the cycle after its trigger
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fspa_pkg.sv =====
package fspa_pkg;

  localparam int ADDR_W     = 32;
  localparam int OBJ_W      = 13;
  localparam int SIZE_W     = 14;
  localparam int CNT_W      = 9;
  localparam int QUO_W      = CNT_W;
  localparam int OFF_W      = SIZE_W + QUO_W - 1;
  localparam int LIMIT_W    = CNT_W + SIZE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PTR_BYTES  = 8;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP  = 2'd2;

  localparam logic [ADDR_W-1:0] BASE_RST = 32'd4096;
  localparam logic [OBJ_W-1:0]  OBJ_RST  = 13'd8;
  localparam logic [CNT_W-1:0]  CAP_RST  = 9'd256;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REBUILD = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NULL      = 2'd3
  } status_t;

  // Effective pool geometry derived from the registers
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  cap;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [OFF_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic             rem_zero;
  } div_rsp_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] slot_address;
    logic [CNT_W-1:0]  allocated_count;
    logic [CNT_W-1:0]  high_water_mark;
    logic [CNT_W-1:0]  available_count;
    logic              pool_empty;
    logic              pool_full;
  } res_t;

endpackage

// ===== rtl/core/fspa_if.sv =====
interface fspa_req_if import fspa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ADDR_W-1:0] address;

  modport source (output valid, cmd, address, input ready);
  modport sink   (input valid, cmd, address, output ready);
endinterface

interface fspa_rsp_if import fspa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] slot_address;
  logic [CNT_W-1:0]  allocated_count;
  logic [CNT_W-1:0]  high_water_mark;
  logic [CNT_W-1:0]  available_count;
  logic              pool_empty;
  logic              pool_full;

  modport source (output valid, status, slot_address, allocated_count, high_water_mark,
                  available_count, pool_empty, pool_full, input ready);
  modport sink   (input valid, status, slot_address, allocated_count, high_water_mark,
                  available_count, pool_empty, pool_full, output ready);
endinterface

// ===== rtl/core/fspa_div.sv =====
module fspa_div import fspa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [OFF_W-1:0]  rem;
  logic [OFF_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic              ge;

  // One restoring step: compare and subtract the shifted divisor
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      // Pulse done on the cycle after the last step
      done <= busy && !req.start && (step == STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(QUO_W);
        rem  <= req.dividend;
        dsh  <= {req.divisor, {(QUO_W-1){1'b0}}};
        quo  <= '0;
      end else if (busy) begin
        quo  <= {quo[QUO_W-2:0], ge};
        rem  <= ge ? (rem - dsh) : rem;
        dsh  <= dsh >> 1;
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;
  assign rsp.rem_zero = (rem == '0);

endmodule

// ===== rtl/core/fspa_ctrl.sv =====
module fspa_ctrl import fspa_pkg::*; #(
  parameter int MAX_SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  fspa_req_if.sink          req,
  fspa_rsp_if.source        rsp,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp
);

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int LIM_W  = $clog2(MAX_SLOTS + 1);
  localparam int LINK_W = IDX_W + 1;
  localparam int PROD_W = IDX_W + SIZE_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_ALLOC = 7'b0000100,
    S_FCHK  = 7'b0001000,
    S_FDIV  = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t             state;
  cmd_t               cmd_q;
  logic [ADDR_W-1:0]  addr_q;
  status_t            status_q;
  logic [ADDR_W-1:0]  slot_q;
  logic [ADDR_W-1:0]  off_q;
  logic [PROD_W-1:0]  prod_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [IDX_W-1:0]   head;
  logic               head_valid;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   peak;
  logic [IDX_W-1:0]   ptr;
  logic [LIM_W-1:0]   sweep_lim;
  logic               sweep_rsp;
  logic               res_valid;
  res_t               res_q;

  // Link store: bit IDX_W marks a live link
  logic [LINK_W-1:0]  links [MAX_SLOTS];
  logic [LINK_W-1:0]  rd_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [LINK_W-1:0]  mem_wd;

  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_dec;
  logic [LIM_W-1:0]   sweep_nxt;
  logic               sweep_lnk;
  logic               range_bad;
  logic [IDX_W-1:0]   div_idx;
  logic               push_ok;
  logic [CNT_W-1:0]   avail;

  always_comb begin
    cnt_inc   = (count < COUNT_LIMIT) ? (count + 1'b1) : count;
    cnt_dec   = (count != '0) ? (count - 1'b1) : count;
    sweep_nxt = LIM_W'(ptr) + LIM_W'(1);
    sweep_lnk = (sweep_nxt < sweep_lim);
    range_bad = (off_q >= ADDR_W'(limit_q));
    div_idx   = IDX_W'(div_rsp.quotient);
    push_ok   = (state == S_FDIV) && div_rsp.done && div_rsp.rem_zero;
    avail     = (count < cfg.cap) ? (cfg.cap - count) : '0;

    // Write port: rebuild sweep or a pushed slot
    mem_we = 1'b0;
    mem_wa = ptr;
    mem_wd = {sweep_lnk, sweep_lnk ? IDX_W'(sweep_nxt) : IDX_W'(0)};
    if (state == S_SWEEP) begin
      mem_we = 1'b1;
    end else if (push_ok) begin
      mem_we = 1'b1;
      mem_wa = div_idx;
      mem_wd = {head_valid, head};
    end

    div_req.start    = (state == S_FCHK) && !range_bad;
    div_req.dividend = off_q[OFF_W-1:0];
    div_req.divisor  = cfg.size;
  end

  // Link memory, registered read at the head slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      links[mem_wa] <= mem_wd;
    end
    rd_q <= links[head];
  end

  // Hold the free-range bound for the free check
  always_ff @(posedge clk) begin
    limit_q <= LIMIT_W'(cfg.cap) * LIMIT_W'(cfg.size);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      ptr        <= '0;
      sweep_lim  <= LIM_W'(MAX_SLOTS);
      sweep_rsp  <= 1'b0;
      head       <= '0;
      head_valid <= 1'b1;
      count      <= '0;
      peak       <= '0;
      res_valid  <= 1'b0;
    end else begin
      // Drop a taken beat unless a new result replaces it this cycle
      if (res_valid && rsp.ready && (state != S_FIN)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q    <= cmd_t'(req.cmd);
            addr_q   <= req.address;
            status_q <= ST_OK;
            slot_q   <= '0;
            state    <= S_DISP;
          end
        end
        S_DISP: begin
          case (cmd_q)
            CMD_ALLOC: begin
              if (!head_valid) begin
                status_q <= ST_EXHAUSTED;
                state    <= S_FIN;
              end else begin
                prod_q <= PROD_W'(head) * PROD_W'(cfg.size);
                state  <= S_ALLOC;
              end
            end
            CMD_FREE: begin
              if (addr_q == '0) begin
                status_q <= ST_NULL;
                state    <= S_FIN;
              end else if (addr_q < cfg.base) begin
                status_q <= ST_RANGE;
                state    <= S_FIN;
              end else begin
                off_q <= addr_q - cfg.base;
                state <= S_FCHK;
              end
            end
            CMD_REBUILD: begin
              ptr       <= '0;
              sweep_lim <= LIM_W'(cfg.cap);
              sweep_rsp <= 1'b1;
              state     <= S_SWEEP;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_ALLOC: begin
          slot_q     <= cfg.base + ADDR_W'(prod_q);
          head       <= rd_q[IDX_W-1:0];
          head_valid <= rd_q[IDX_W];
          count      <= cnt_inc;
          if (cnt_inc > peak) begin
            peak <= cnt_inc;
          end
          state <= S_FIN;
        end
        S_FCHK: begin
          if (range_bad) begin
            status_q <= ST_RANGE;
            state    <= S_FIN;
          end else begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            if (div_rsp.rem_zero) begin
              head       <= div_idx;
              head_valid <= 1'b1;
              count      <= cnt_dec;
            end else begin
              status_q <= ST_RANGE;
            end
            state <= S_FIN;
          end
        end
        S_SWEEP: begin
          ptr <= ptr + 1'b1;
          if (ptr == IDX_W'(MAX_SLOTS - 1)) begin
            head       <= '0;
            head_valid <= 1'b1;
            count      <= '0;
            sweep_rsp  <= 1'b0;
            state      <= sweep_rsp ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          // Load the result once the output register is free
          if (!res_valid || rsp.ready) begin
            res_q.status          <= status_q;
            res_q.slot_address    <= slot_q;
            res_q.allocated_count <= count;
            res_q.high_water_mark <= peak;
            res_q.available_count <= avail;
            res_q.pool_empty      <= (count == '0);
            res_q.pool_full       <= (count >= cfg.cap);
            res_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = res_valid;
  assign rsp.status          = res_q.status;
  assign rsp.slot_address    = res_q.slot_address;
  assign rsp.allocated_count = res_q.allocated_count;
  assign rsp.high_water_mark = res_q.high_water_mark;
  assign rsp.available_count = res_q.available_count;
  assign rsp.pool_empty      = res_q.pool_empty;
  assign rsp.pool_full       = res_q.pool_full;

endmodule

// ===== rtl/core/fixed_slot_pool_allocator_unit.sv =====
// Fixed-size slot pool allocator. The free slots form a linked list held in an internal
// link memory of MAX_SLOTS entries; each command on req yields one beat on rsp with its
// status and the pool statistics. Allocate does one link memory read and one
// index-by-size multiply; free runs the byte offset through the 9-step divider, which
// turns it into a slot index and checks alignment; rebuild sweeps all MAX_SLOTS entries,
// one link written per cycle. req.ready rises again together with rsp.valid, when the result is
// loaded, and the next command is accepted from the idle state.
// After reset the same pass runs over all MAX_SLOTS entries with req.ready low, so the
// first command is taken only once that pass is done; configuration writes are
// taken throughout. One command is in flight at a time, and a waiting result does not
// stop the next command from being accepted. Write the registers only while no command
// is outstanding; a new capacity reaches the free list only through a rebuild.
module fixed_slot_pool_allocator_unit import fspa_pkg::*; #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  fspa_req_if.sink              req,
  fspa_rsp_if.source            rsp,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  localparam logic [SIZE_W-1:0] SIZE_MASK = ~SIZE_W'(PTR_BYTES - 1);

  logic [ADDR_W-1:0] base_reg;
  logic [OBJ_W-1:0]  obj_reg;
  logic [CNT_W-1:0]  cap_reg;
  logic [SIZE_W-1:0] obj_round;
  cfg_t              cfg;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= BASE_RST;
      obj_reg  <= OBJ_RST;
      cap_reg  <= CAP_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BASE: base_reg <= wr_data[ADDR_W-1:0];
        REG_OBJ:  obj_reg  <= wr_data[OBJ_W-1:0];
        REG_CAP:  cap_reg  <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Derive slot size and the clamped capacity
  always_comb begin
    obj_round = (SIZE_W'(obj_reg) + SIZE_W'(PTR_BYTES - 1)) & SIZE_MASK;
    cfg.base  = base_reg;
    cfg.size  = (obj_reg == '0) ? SIZE_W'(PTR_BYTES) : obj_round;
    if (cap_reg == '0) begin
      cfg.cap = CNT_W'(1);
    end else if (32'(cap_reg) > 32'(MAX_SLOTS)) begin
      cfg.cap = CNT_W'(MAX_SLOTS);
    end else begin
      cfg.cap = cap_reg;
    end
  end

  fspa_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (req),
    .rsp     (rsp),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  fspa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// ===== rtl/core/fspa_checker.sv =====
`include "assert_macros.svh"

module fspa_checker import fspa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [1:0]        status,
  input logic [ADDR_W-1:0] slot_address,
  input logic [CNT_W-1:0]  allocated_count,
  input logic [CNT_W-1:0]  high_water_mark,
  input logic [CNT_W-1:0]  available_count,
  input logic              pool_empty,
  input logic              pool_full
);

  // Stalled result beat holds
  `AST_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(slot_address) && $stable(allocated_count), "result beat changed while stalled")

  // Peak never below the current count
  `AST_WHEN(a_peak, clk, rst, rsp_valid, allocated_count <= high_water_mark, "high water mark below allocated count")

  // Full exactly when nothing is left
  `AST_WHEN(a_full, clk, rst, rsp_valid, pool_full == (available_count == '0), "pool full disagrees with available count")

  // Empty exactly when nothing is allocated
  `AST_WHEN(a_empty, clk, rst, rsp_valid, pool_empty == (allocated_count == '0), "pool empty disagrees with allocated count")

  // Only a good allocation carries an address
  `AST_WHEN(a_addr, clk, rst, rsp_valid && (status != ST_OK), slot_address == '0, "address on a failed command")

endmodule

bind fixed_slot_pool_allocator_unit fspa_checker u_fspa_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .status          (rsp.status),
  .slot_address    (rsp.slot_address),
  .allocated_count (rsp.allocated_count),
  .high_water_mark (rsp.high_water_mark),
  .available_count (rsp.available_count),
  .pool_empty      (rsp.pool_empty),
  .pool_full       (rsp.pool_full)
);
